FILE: sv/bsc_pkg.sv
// Shared widths, request side-band types and arithmetic helpers for the compensation block.
package bsc_pkg;

  localparam int DATA_W    = 32;
  localparam int RAW_W     = 16;
  localparam int DIV_STEPS = 32;
  localparam int IDX_W     = 3;

  // calibration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_AC1 = 3'd0, REG_AC2 = 3'd1, REG_AC3 = 3'd2, REG_AC4 = 3'd3,
    REG_AC5 = 3'd4, REG_AC6 = 3'd5, REG_B1_B2 = 3'd6, REG_MC_MD = 3'd7
  } reg_idx_t;

  // side-band carried through the temperature divider
  typedef struct packed {
    logic [DATA_W-1:0] x1;
    logic [RAW_W-1:0]  up;
    logic              act;
    logic              neg;
    logic              terr;
  } tside_t;

  // side-band carried through the pressure divider
  typedef struct packed {
    logic [DATA_W-1:0] temp;
    logic              act;
    logic              terr;
    logic              perr;
    logic              dbl;
  } pside_t;

  // arithmetic right shift of a two's complement word
  function automatic logic [DATA_W-1:0] asr(input logic [DATA_W-1:0] x, input int n);
    asr = $unsigned($signed(x) >>> n);
  endfunction

  // sign-extend a 16-bit word
  function automatic logic [DATA_W-1:0] sx16(input logic [RAW_W-1:0] v);
    sx16 = {{(DATA_W-RAW_W){v[RAW_W-1]}}, v};
  endfunction

endpackage

FILE: sv/bsc_div_cell.sv
// One restoring-division cell: resolves one quotient bit and hands the request on.
module bsc_div_cell #(
  parameter int SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      valid_in,
  input  logic [bsc_pkg::DATA_W-1:0] rem_in,
  input  logic [bsc_pkg::DATA_W-1:0] num_in,
  input  logic [bsc_pkg::DATA_W-1:0] den_in,
  input  logic [SIDE_W-1:0]         side_in,
  output logic                      valid_out,
  output logic [bsc_pkg::DATA_W-1:0] rem_out,
  output logic [bsc_pkg::DATA_W-1:0] num_out,
  output logic [bsc_pkg::DATA_W-1:0] den_out,
  output logic [SIDE_W-1:0]         side_out
);

  logic [bsc_pkg::DATA_W:0] shifted;
  logic [bsc_pkg::DATA_W:0] diff;
  logic                     ge;

  // shift in the next dividend bit and trial-subtract
  always_comb begin
    shifted = {rem_in, num_in[bsc_pkg::DATA_W-1]};
    diff    = shifted - {1'b0, den_in};
    ge      = shifted >= {1'b0, den_in};
  end

  // advance the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  // hold partial remainder, quotient bits and side-band
  always_ff @(posedge clk) begin
    rem_out  <= ge ? diff[bsc_pkg::DATA_W-1:0] : shifted[bsc_pkg::DATA_W-1:0];
    num_out  <= {num_in[bsc_pkg::DATA_W-2:0], ge};
    den_out  <= den_in;
    side_out <= side_in;
  end

endmodule

FILE: sv/bsc_div_chain.sv
// Row of division cells giving an unsigned 32-bit quotient, one bit per cell.
module bsc_div_chain #(
  parameter int SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      valid_in,
  input  logic [bsc_pkg::DATA_W-1:0] num,
  input  logic [bsc_pkg::DATA_W-1:0] den,
  input  logic [SIDE_W-1:0]         side_in,
  output logic                      valid_out,
  output logic [bsc_pkg::DATA_W-1:0] quot,
  output logic [SIDE_W-1:0]         side_out
);

  logic                      v_w   [bsc_pkg::DIV_STEPS+1];
  logic [bsc_pkg::DATA_W-1:0] rem_w [bsc_pkg::DIV_STEPS+1];
  logic [bsc_pkg::DATA_W-1:0] num_w [bsc_pkg::DIV_STEPS+1];
  logic [bsc_pkg::DATA_W-1:0] den_w [bsc_pkg::DIV_STEPS+1];
  logic [SIDE_W-1:0]         sd_w  [bsc_pkg::DIV_STEPS+1];

  // feed the first cell
  assign v_w[0]   = valid_in;
  assign rem_w[0] = '0;
  assign num_w[0] = num;
  assign den_w[0] = den;
  assign sd_w[0]  = side_in;

  // build the row
  for (genvar i = 0; i < bsc_pkg::DIV_STEPS; i++) begin : g_cell
    bsc_div_cell #(.SIDE_W(SIDE_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (v_w[i]),
      .rem_in   (rem_w[i]),
      .num_in   (num_w[i]),
      .den_in   (den_w[i]),
      .side_in  (sd_w[i]),
      .valid_out(v_w[i+1]),
      .rem_out  (rem_w[i+1]),
      .num_out  (num_w[i+1]),
      .den_out  (den_w[i+1]),
      .side_out (sd_w[i+1])
    );
  end

  // the shifted dividend word has become the quotient
  assign valid_out = v_w[bsc_pkg::DIV_STEPS];
  assign quot      = num_w[bsc_pkg::DIV_STEPS];
  assign side_out  = sd_w[bsc_pkg::DIV_STEPS];

endmodule

FILE: sv/barometric_sensor_compensation.sv
// Pressure/temperature compensation pipeline: takes a request on every cycle (busy stays low) and
// presents each result on done; each request passes through two rows of 32 division cells
// (temperature, then pressure) on its way. Results cannot be held off.
module barometric_sensor_compensation (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [bsc_pkg::RAW_W-1:0]          raw_temp,
  input  logic [bsc_pkg::RAW_W-1:0]          raw_pressure,
  input  logic                               action,
  input  logic                               cfg_we,
  input  logic [bsc_pkg::IDX_W-1:0]          cfg_index,
  input  logic [bsc_pkg::DATA_W-1:0]         cfg_data,
  output logic                               done,
  output logic signed [bsc_pkg::DATA_W-1:0]  value,
  output logic                               div_error
);

  typedef struct packed {
    logic [bsc_pkg::DATA_W-1:0] temp;
    logic [bsc_pkg::RAW_W-1:0]  up;
    logic                       act;
    logic                       terr;
  } mid_t;

  localparam logic [31:0] C4000  = 32'd4000;
  localparam logic [31:0] C50000 = 32'd50000;
  localparam logic [31:0] C32768 = 32'd32768;
  localparam logic [31:0] C3038  = 32'd3038;
  localparam logic [31:0] C3791  = 32'd3791;
  localparam logic [31:0] CM7357 = 32'hFFFF_E343;

  logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6;
  logic [31:0] b1_b2, mc_md;

  assign busy = 1'b0;

  // write calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ac1 <= '0; ac2 <= '0; ac3 <= '0; ac4 <= '0; ac5 <= '0; ac6 <= '0;
      b1_b2 <= '0; mc_md <= '0;
    end else if (cfg_we) begin
      case (bsc_pkg::reg_idx_t'(cfg_index))
        bsc_pkg::REG_AC1:   ac1   <= cfg_data[15:0];
        bsc_pkg::REG_AC2:   ac2   <= cfg_data[15:0];
        bsc_pkg::REG_AC3:   ac3   <= cfg_data[15:0];
        bsc_pkg::REG_AC4:   ac4   <= cfg_data[15:0];
        bsc_pkg::REG_AC5:   ac5   <= cfg_data[15:0];
        bsc_pkg::REG_AC6:   ac6   <= cfg_data[15:0];
        bsc_pkg::REG_B1_B2: b1_b2 <= cfg_data;
        bsc_pkg::REG_MC_MD: mc_md <= cfg_data;
        default:            ac1   <= ac1;
      endcase
    end
  end

  logic [31:0] ac1_s, ac2_s, ac3_s, b1_s, b2_s, mc_s, md_s;
  assign ac1_s = bsc_pkg::sx16(ac1);
  assign ac2_s = bsc_pkg::sx16(ac2);
  assign ac3_s = bsc_pkg::sx16(ac3);
  assign b1_s  = bsc_pkg::sx16(b1_b2[31:16]);
  assign b2_s  = bsc_pkg::sx16(b1_b2[15:0]);
  assign mc_s  = bsc_pkg::sx16(mc_md[31:16]);
  assign md_s  = bsc_pkg::sx16(mc_md[15:0]);

  // valid flags of the registered stages
  logic v0, v1, v2, va, vb, vc, vd, ve, vf, vg, vh, vj, vk, vl;
  logic tq_v, pq_v;

  // ---------------- temperature front end ----------------
  logic [15:0] ut0, up0, up1, up2;
  logic        act0, act1, act2;
  logic [31:0] prod1, x1_2, d2;

  // capture the request, form (UT-AC6)*AC5, then X1 and its divisor
  always_ff @(posedge clk) begin
    ut0   <= raw_temp;
    up0   <= raw_pressure;
    act0  <= action;
    prod1 <= ({16'd0, ut0} - {16'd0, ac6}) * {16'd0, ac5};
    up1   <= up0;
    act1  <= act0;
    x1_2  <= bsc_pkg::asr(prod1, 15);
    d2    <= bsc_pkg::asr(prod1, 15) + md_s;
    up2   <= up1;
    act2  <= act1;
  end

  // load the temperature divider with magnitudes of MC<<11 and X1+MD
  logic [31:0]     tnum_s, tnum, tden;
  bsc_pkg::tside_t tside_in, tside_out;
  logic [31:0]     tq;
  always_comb begin
    tnum_s        = mc_s << 11;
    tnum          = tnum_s[31] ? (32'd0 - tnum_s) : tnum_s;
    tden          = d2[31] ? (32'd0 - d2) : d2;
    tside_in.x1   = x1_2;
    tside_in.up   = up2;
    tside_in.act  = act2;
    tside_in.neg  = tnum_s[31] ^ d2[31];
    tside_in.terr = (d2 == 32'd0);
  end

  bsc_div_chain #(.SIDE_W($bits(bsc_pkg::tside_t))) u_tdiv (
    .clk      (clk),
    .rst      (rst),
    .valid_in (v2),
    .num      (tnum),
    .den      (tden),
    .side_in  (tside_in),
    .valid_out(tq_v),
    .quot     (tq),
    .side_out (tside_out)
  );

  // ---------------- pressure coefficient stages ----------------
  mid_t        ma, mb, mc, md, me, mf, mg, mh;
  logic [31:0] x2t, b5;
  logic [31:0] b6a, sqp_b, mac2_b, mac3_b, sq_c, x2a_c, x1c_c;
  logic [31:0] pb2_d, pb1_d, x2a_d, x1c_d, x3_e, x3b_e, b3n, b3_f, s_f;
  logic [31:0] b4p_g, diff_g, b4_h, b7_h;

  always_comb begin
    x2t = tside_out.neg ? (32'd0 - tq) : tq;
    b5  = tside_out.x1 + x2t;
    b3n = (ac1_s << 2) + x3_e + 32'd2;
  end

  // B5, B6, products with B6, shifts, B3 and B4 terms, B7
  always_ff @(posedge clk) begin
    ma.temp <= bsc_pkg::asr(b5 + 32'd8, 4);
    ma.up   <= tside_out.up;
    ma.act  <= tside_out.act;
    ma.terr <= tside_out.terr;
    b6a     <= b5 - C4000;
    mb      <= ma;
    sqp_b   <= b6a * b6a;
    mac2_b  <= ac2_s * b6a;
    mac3_b  <= ac3_s * b6a;
    mc      <= mb;
    sq_c    <= bsc_pkg::asr(sqp_b, 12);
    x2a_c   <= bsc_pkg::asr(mac2_b, 11);
    x1c_c   <= bsc_pkg::asr(mac3_b, 13);
    md      <= mc;
    pb2_d   <= b2_s * sq_c;
    pb1_d   <= b1_s * sq_c;
    x2a_d   <= x2a_c;
    x1c_d   <= x1c_c;
    me      <= md;
    x3_e    <= bsc_pkg::asr(pb2_d, 11) + x2a_d;
    x3b_e   <= bsc_pkg::asr(x1c_d + bsc_pkg::asr(pb1_d, 16) + 32'd2, 2);
    mf      <= me;
    b3_f    <= b3n[31] ? bsc_pkg::asr(b3n + 32'd3, 2) : bsc_pkg::asr(b3n, 2);
    s_f     <= x3b_e + C32768;
    mg      <= mf;
    b4p_g   <= {16'd0, ac4} * s_f;
    diff_g  <= {16'd0, mf.up} - b3_f;
    mh      <= mg;
    b4_h    <= b4p_g >> 15;
    b7_h    <= diff_g * C50000;
  end

  // load the pressure divider; large B7 is divided first and doubled after
  logic [31:0]     pnum, pq;
  bsc_pkg::pside_t pside_in, pside_out;
  always_comb begin
    pnum           = b7_h[31] ? b7_h : (b7_h << 1);
    pside_in.temp  = mh.temp;
    pside_in.act   = mh.act;
    pside_in.terr  = mh.terr;
    pside_in.perr  = (b4_h == 32'd0);
    pside_in.dbl   = b7_h[31];
  end

  bsc_div_chain #(.SIDE_W($bits(bsc_pkg::pside_t))) u_pdiv (
    .clk      (clk),
    .rst      (rst),
    .valid_in (vh),
    .num      (pnum),
    .den      (b4_h),
    .side_in  (pside_in),
    .valid_out(pq_v),
    .quot     (pq),
    .side_out (pside_out)
  );

  // ---------------- pressure correction and result ----------------
  bsc_pkg::pside_t sj, sk, sl;
  logic [31:0] p_j, p_k, p_l, t_j, sq_k, m2_k, m1_l, x2_l, x1_m, pres;

  assign t_j = bsc_pkg::asr(p_j, 8);

  always_ff @(posedge clk) begin
    sj   <= pside_out;
    p_j  <= pside_out.dbl ? (pq << 1) : pq;
    sk   <= sj;
    p_k  <= p_j;
    sq_k <= t_j * t_j;
    m2_k <= CM7357 * p_j;
    sl   <= sk;
    p_l  <= p_k;
    m1_l <= sq_k * C3038;
    x2_l <= bsc_pkg::asr(m2_k, 16);
  end

  always_comb begin
    x1_m = bsc_pkg::asr(m1_l, 16);
    pres = p_l + bsc_pkg::asr(x1_m + x2_l + C3791, 4);
  end

  // select the result and error flag
  always_ff @(posedge clk) begin
    if (sl.terr) begin
      value     <= '0;
      div_error <= 1'b1;
    end else if (!sl.act) begin
      value     <= sl.temp;
      div_error <= 1'b0;
    end else if (sl.perr) begin
      value     <= '0;
      div_error <= 1'b1;
    end else begin
      value     <= pres;
      div_error <= 1'b0;
    end
  end

  // advance request valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0;
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0;
      ve <= 1'b0; vf <= 1'b0; vg <= 1'b0; vh <= 1'b0;
      vj <= 1'b0; vk <= 1'b0; vl <= 1'b0; done <= 1'b0;
    end else begin
      v0 <= start & ~busy; v1 <= v0; v2 <= v1;
      va <= tq_v; vb <= va; vc <= vb; vd <= vc;
      ve <= vd; vf <= ve; vg <= vf; vh <= vg;
      vj <= pq_v; vk <= vj; vl <= vk; done <= vl;
    end
  end

endmodule

FILE: test/barometric_sensor_compensation_tb.sv
// Self-checking testbench for the barometric compensation block: directed table, then random.
`timescale 1ns / 1ps

module barometric_sensor_compensation_tb;

  localparam int NUM_REGS    = 8;
  localparam int DRAIN_WAIT  = 85;
  localparam int STALL_LIMIT = 4000;

  // calibration sets used by the directed table
  localparam int SET_RESET = 0;
  localparam int SET_TYP   = 1;
  localparam int SET_NOAC4 = 2;
  localparam int SET_NOTMP = 3;

  typedef struct packed {
    logic [bsc_pkg::DATA_W-1:0] val;
    logic                       err;
  } reading_t;

  typedef struct {
    int              cal_set;
    logic [15:0]     ut;
    logic [15:0]     up;
    logic            act;
    logic            known;
    logic [31:0]     kval;
    logic            kerr;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [bsc_pkg::RAW_W-1:0] raw_temp = '0;
  logic [bsc_pkg::RAW_W-1:0] raw_pressure = '0;
  logic action = 1'b0;
  logic cfg_we = 1'b0;
  logic [bsc_pkg::IDX_W-1:0] cfg_index = '0;
  logic [bsc_pkg::DATA_W-1:0] cfg_data = '0;
  logic done;
  logic signed [bsc_pkg::DATA_W-1:0] value;
  logic div_error;

  // side data travelling with the request for typed expectations
  logic row_known = 1'b0;
  reading_t row_exp = '0;

  logic [31:0] cal_regs [NUM_REGS];
  reading_t pending_readings [$];
  int errors = 0;
  int stall_cycles = 0;
  int idle_pct = 0;

  barometric_sensor_compensation dut (.*);

  always #1 clk = ~clk;

  function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // signed divide, truncating toward zero
  function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? 32'd0 - a : a;
    mb = b[31] ? 32'd0 - b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? 32'd0 - q : q;
  endfunction

  // compensate one reading pair with the current calibration copy
  function automatic reading_t compensate(input logic [15:0] ut_in, input logic [15:0] up_in,
                                          input logic act);
    logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, b5, b6, b3, b4, b7, p, d, sq;
    reading_t r;
    ut = {16'd0, ut_in};
    up = {16'd0, up_in};
    ac1 = ext16(cal_regs[bsc_pkg::REG_AC1][15:0]);
    ac2 = ext16(cal_regs[bsc_pkg::REG_AC2][15:0]);
    ac3 = ext16(cal_regs[bsc_pkg::REG_AC3][15:0]);
    ac4 = {16'd0, cal_regs[bsc_pkg::REG_AC4][15:0]};
    ac5 = {16'd0, cal_regs[bsc_pkg::REG_AC5][15:0]};
    ac6 = {16'd0, cal_regs[bsc_pkg::REG_AC6][15:0]};
    b1 = ext16(cal_regs[bsc_pkg::REG_B1_B2][31:16]);
    b2 = ext16(cal_regs[bsc_pkg::REG_B1_B2][15:0]);
    mc = ext16(cal_regs[bsc_pkg::REG_MC_MD][31:16]);
    md = ext16(cal_regs[bsc_pkg::REG_MC_MD][15:0]);
    r = '0;
    x1 = (ut - ac6) * ac5;
    x1 = sra32(x1, 15);
    d = x1 + md;
    if (d == 32'd0) begin
      r.err = 1'b1;
    end else begin
      x2 = div_trunc(mc << 11, d);
      b5 = x1 + x2;
      if (!act) begin
        r.val = sra32(b5 + 32'd8, 4);
      end else begin
        b6 = b5 - 32'd4000;
        sq = sra32(b6 * b6, 12);
        x1 = sra32(b2 * sq, 11);
        x2 = sra32(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = div_trunc(ac1 * 32'd4 + x3 + 32'd2, 32'd4);
        x1 = sra32(ac3 * b6, 13);
        x2 = sra32(b1 * sq, 16);
        x3 = sra32(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 32'd0) begin
          r.err = 1'b1;
        end else begin
          b7 = (up - b3) * 32'd50000;
          if (!b7[31]) p = (b7 * 32'd2) / b4;
          else p = (b7 / b4) * 32'd2;
          x1 = sra32(p, 8);
          x1 = x1 * x1;
          x1 = sra32(x1 * 32'd3038, 16);
          x2 = sra32((32'd0 - 32'd7357) * p, 16);
          r.val = p + sra32(x1 + x2 + 32'd3791, 4);
        end
      end
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // queue the expected reading on each accepted request, check each strobed result
  always @(posedge clk) begin
    if (!rst && start && !busy)
      pending_readings.push_back(row_known ? row_exp
                                           : compensate(raw_temp, raw_pressure, action));
    if (!rst && done) begin
      if (pending_readings.size() == 0) begin
        report("unexpected result", value, 32'd0);
      end else begin
        reading_t e;
        e = pending_readings.pop_front();
        if (value !== e.val) report("value", value, e.val);
        if (div_error !== e.err) report("div_error", {31'd0, div_error}, {31'd0, e.err});
      end
    end
  end

  // stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // wait until no result is outstanding, plus the pipeline depth
  task automatic drain();
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // write all calibration registers while idle
  task automatic program_cal(input logic [31:0] vals [NUM_REGS]);
    start <= 1'b0;
    drain();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[bsc_pkg::IDX_W-1:0];
      cfg_data <= vals[i];
      @(posedge clk);
      cal_regs[i] = vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  // issue one request and hold it until taken; idle at random afterwards
  task automatic send(input logic [15:0] ut, input logic [15:0] up, input logic act,
                      input logic known, input reading_t kexp);
    start <= 1'b1;
    raw_temp <= ut;
    raw_pressure <= up;
    action <= act;
    row_known <= known;
    row_exp <= kexp;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // calibration sets for the directed table
  task automatic fixed_set(input int sel, output logic [31:0] v [NUM_REGS]);
    v[bsc_pkg::REG_AC1] = 32'd408;
    v[bsc_pkg::REG_AC2] = {16'd0, 16'hFFB8};
    v[bsc_pkg::REG_AC3] = {16'd0, 16'hC7D1};
    v[bsc_pkg::REG_AC4] = 32'd32741;
    v[bsc_pkg::REG_AC5] = 32'd32757;
    v[bsc_pkg::REG_AC6] = 32'd23153;
    v[bsc_pkg::REG_B1_B2] = {16'd6190, 16'd4};
    v[bsc_pkg::REG_MC_MD] = {16'hDDF9, 16'd2868};
    if (sel == SET_RESET) for (int i = 0; i < NUM_REGS; i++) v[i] = 32'd0;
    if (sel == SET_NOAC4) v[bsc_pkg::REG_AC4] = 32'd0;
    if (sel == SET_NOTMP) begin
      v[bsc_pkg::REG_AC5] = 32'd0;
      v[bsc_pkg::REG_MC_MD] = {16'h1234, 16'd0};
    end
  endtask

  // random calibration of several flavors
  task automatic random_set(input int flavor, output logic [31:0] v [NUM_REGS]);
    fixed_set(SET_TYP, v);
    for (int i = 0; i < NUM_REGS; i++) begin
      case (flavor)
        0: v[i] = v[i] ^ ($urandom() & 32'h00FF00FF);
        1: v[i] = $urandom();
        2: v[i] = {pick_extreme(), pick_extreme()};
        default: v[i] = (i == bsc_pkg::REG_AC4 || i == bsc_pkg::REG_AC5) ? 32'd0 : $urandom();
      endcase
    end
    if (flavor == 3 && $urandom_range(1)) v[bsc_pkg::REG_MC_MD][15:0] = 16'd0;
  endtask

  row_t dir_rows [] = '{
    '{SET_RESET, 16'h0000, 16'h0000, 1'b0, 1'b1, 32'd0, 1'b1},
    '{SET_RESET, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 32'd0, 1'b1},
    '{SET_RESET, 16'h8000, 16'h7FFF, 1'b0, 1'b1, 32'd0, 1'b1},
    '{SET_RESET, 16'h1234, 16'hABCD, 1'b1, 1'b1, 32'd0, 1'b1},
    '{SET_TYP,   16'd27898, 16'd23843, 1'b0, 1'b0, 32'd0, 1'b0},
    '{SET_TYP,   16'd27898, 16'd23843, 1'b1, 1'b0, 32'd0, 1'b0},
    '{SET_TYP,   16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0, 1'b0},
    '{SET_TYP,   16'h0000, 16'h0000, 1'b1, 1'b0, 32'd0, 1'b0},
    '{SET_TYP,   16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 32'd0, 1'b0},
    '{SET_TYP,   16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 32'd0, 1'b0},
    '{SET_TYP,   16'hFFFF, 16'h0000, 1'b1, 1'b0, 32'd0, 1'b0},
    '{SET_TYP,   16'h0000, 16'hFFFF, 1'b1, 1'b0, 32'd0, 1'b0},
    '{SET_TYP,   16'h8000, 16'h8000, 1'b1, 1'b0, 32'd0, 1'b0},
    '{SET_NOAC4, 16'd27898, 16'd23843, 1'b1, 1'b1, 32'd0, 1'b1},
    '{SET_NOAC4, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 32'd0, 1'b1},
    '{SET_NOAC4, 16'd27898, 16'h0000, 1'b0, 1'b0, 32'd0, 1'b0},
    '{SET_NOTMP, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 32'd0, 1'b1},
    '{SET_NOTMP, 16'h0000, 16'h0000, 1'b0, 1'b1, 32'd0, 1'b1}
  };

  initial begin
    logic [31:0] cal_vals [NUM_REGS];
    int cur_set;
    int flavor;
    for (int i = 0; i < NUM_REGS; i++) cal_regs[i] = 32'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; reprogram when the calibration set changes
    cur_set = SET_RESET;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cal_set != cur_set) begin
        cur_set = dir_rows[i].cal_set;
        fixed_set(cur_set, cal_vals);
        program_cal(cal_vals);
      end
      send(dir_rows[i].ut, dir_rows[i].up, dir_rows[i].act, dir_rows[i].known,
           '{val: dir_rows[i].kval, err: dir_rows[i].kerr});
    end

    // random phases: light idling, heavy idling, then back to back
    for (int ph = 0; ph < 10; ph++) begin
      idle_pct = (ph < 4) ? 7 : (ph < 7) ? 58 : 0;
      flavor = ph % 4;
      random_set(flavor, cal_vals);
      program_cal(cal_vals);
      for (int n = 0; n < 115; n++) begin
        if (n == 60) begin
          start <= 1'b0;
          while (pending_readings.size() != 0) @(posedge clk);
        end
        send(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
             1'($urandom_range(1)), 1'b0, '0);
      end
    end

    start <= 1'b0;
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
